// ===== hdl/base64_codec_top_defines.svh =====
// assertion macros for the base64 codec
// no dependencies; included by b64c_back, the module that carries assertions
`ifndef BASE64_CODEC_TOP_DEFINES_SVH
`define BASE64_CODEC_TOP_DEFINES_SVH

`ifndef SYNTH
// antecedent implies consequent in the same cycle
`define B64C_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("b64c assertion failed");
// condition must never hold
`define B64C_ASSERT_NEVER(lbl, clk_s, rst_s, cond) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) !(cond)) \
    else $error("b64c assertion failed");
`else
`define B64C_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons)
`define B64C_ASSERT_NEVER(lbl, clk_s, rst_s, cond)
`endif

`endif

// ===== hdl/b64c_pkg.sv =====
// shared types, constants and alphabet functions for the base64 codec
// no dependencies
`default_nettype none

package b64c_pkg;

  // mode register codes
  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  localparam logic [7:0] PAD_CHAR     = 8'd61;
  localparam logic [6:0] INVALID_CODE = 7'd64;

  // job queue sizing
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  // one finished group handed from the front to the back
  typedef struct packed {
    logic        enc;     // 1: characters from a byte group
    logic [23:0] bits;    // group bits, msb first
    logic [1:0]  cnt_m1;  // results in this job minus one
    logic [1:0]  sig_m1;  // encode: real characters minus one, rest are pad
    logic        last;    // job ends the message
    logic        err;     // error flag for every result of the job
  } job_t;

  // six-bit value to alphabet character
  function automatic logic [7:0] enc_char(input logic [5:0] v);
    logic [7:0] w;
    w = {2'b00, v};
    if (v < 6'd26)      return w + 8'd65;
    else if (v < 6'd52) return w + 8'd71;   // 'a' - 26
    else if (v < 6'd62) return w - 8'd4;    // '0' - 52
    else if (v == 6'd62) return 8'd43;
    else                return 8'd47;
  endfunction

  // character to six-bit value, INVALID_CODE when outside the alphabet
  function automatic logic [6:0] dec_value(input logic [7:0] c);
    logic [7:0] r;
    r = 8'd0;
    case (c) inside
      [8'd65:8'd90]:  r = c - 8'd65;
      [8'd97:8'd122]: r = c - 8'd71;
      [8'd48:8'd57]:  r = c + 8'd4;
      8'd43:          r = 8'd62;
      8'd47:          r = 8'd63;
      default:        r = {1'b0, INVALID_CODE};
    endcase
    return r[6:0];
  endfunction

endpackage

`default_nettype wire

// ===== hdl/b64c_ifs.sv =====
// stream and configuration channel interfaces for the base64 codec
// no dependencies
`default_nettype none

// input items: byte and end-of-message mark
interface b64c_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;
  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

// result items: byte, end-of-message mark and error flag
interface b64c_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;
  logic       error;
  modport source (output valid, output out_byte, output out_last, output error,
                  input ready);
  modport sink   (input valid, input out_byte, input out_last, input error,
                  output ready);
endinterface

// mode register write channel
interface b64c_cfg_if;
  logic valid;
  logic ready;
  logic mode;
  modport source (output valid, output mode, input ready);
  modport sink   (input valid, input mode, output ready);
endinterface

`default_nettype wire

// ===== hdl/b64c_front.sv =====
// front end: accepts items, gathers groups and emits one job per finished group and one for a partial final group
// depends on b64c_pkg and the b64c interfaces
`default_nettype none

module b64c_front import b64c_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  b64c_cfg_if.sink    cfg,
  b64c_in_if.sink     src,
  input  wire logic   q_full,
  output logic        q_push,
  output job_t        q_job
);

  logic        mode;
  logic [23:0] group_bits;
  logic [1:0]  group_pos;
  logic [1:0]  pad_count;
  logic        bad_seen;

  logic [23:0] group_bits_next;
  logic [1:0]  group_pos_next;
  logic [1:0]  pad_count_next;
  logic        bad_seen_next;

  logic        accept;
  logic        has_job;
  logic [6:0]  dv;
  logic [5:0]  v;
  logic        is_pad;
  logic [1:0]  pad_n;
  logic        bad_n;
  logic        bad_out;
  logic [23:0] bits_n;

  // a mode write holds off the input for its cycle
  assign cfg.ready = 1'b1;
  assign src.ready = !q_full && !cfg.valid;
  assign accept    = src.valid && src.ready;
  assign q_push    = accept && has_job;

  // group update and job build
  always_comb begin
    dv      = dec_value(src.in_byte);
    v       = 6'd0;
    is_pad  = 1'b0;
    pad_n   = pad_count;
    bad_n   = bad_seen;
    bad_out = bad_seen;
    bits_n  = group_bits;
    has_job = 1'b0;
    q_job   = '0;
    group_bits_next = group_bits;
    group_pos_next  = group_pos;
    pad_count_next  = pad_count;
    bad_seen_next   = bad_seen;

    if (mode == MODE_ENCODE) begin
      case (group_pos)
        2'd0:    bits_n = group_bits | {src.in_byte, 16'd0};
        2'd1:    bits_n = group_bits | {8'd0, src.in_byte, 8'd0};
        default: bits_n = group_bits | {16'd0, src.in_byte};
      endcase
      q_job.enc    = 1'b1;
      q_job.bits   = bits_n;
      q_job.cnt_m1 = 2'd3;
      q_job.sig_m1 = group_pos + 2'd1;
      q_job.last   = src.in_last;
      q_job.err    = 1'b0;
      if (group_pos == 2'd2) begin
        has_job         = 1'b1;
        group_bits_next = 24'd0;
        group_pos_next  = 2'd0;
      end else begin
        has_job         = src.in_last;
        group_bits_next = bits_n;
        group_pos_next  = group_pos + 2'd1;
      end
    end else begin
      // classify the character
      is_pad = (src.in_byte == PAD_CHAR) && group_pos[1] &&
               (group_pos == 2'd3 || pad_count == 2'd0);
      if (is_pad) begin
        if (pad_count != 2'd2) pad_n = pad_count + 2'd1;
      end else if (dv == INVALID_CODE || pad_count != 2'd0) begin
        bad_n = 1'b1;
      end else begin
        v = dv[5:0];
      end
      case (group_pos)
        2'd0:    bits_n = group_bits | {v, 18'd0};
        2'd1:    bits_n = group_bits | {6'd0, v, 12'd0};
        2'd2:    bits_n = group_bits | {12'd0, v, 6'd0};
        default: bits_n = group_bits | {18'd0, v};
      endcase
      bad_out      = bad_n || (pad_n != 2'd0 && !src.in_last);
      q_job.enc    = 1'b0;
      q_job.sig_m1 = 2'd0;
      q_job.last   = src.in_last;
      if (group_pos == 2'd3) begin
        has_job         = 1'b1;
        q_job.bits      = bits_n;
        q_job.cnt_m1    = 2'd2 - pad_n;
        q_job.err       = bad_out;
        group_bits_next = 24'd0;
        group_pos_next  = 2'd0;
        pad_count_next  = 2'd0;
        bad_seen_next   = bad_out;
      end else begin
        // partial final group gives a single error result
        has_job         = src.in_last;
        q_job.bits      = 24'd0;
        q_job.cnt_m1    = 2'd0;
        q_job.err       = 1'b1;
        group_bits_next = bits_n;
        group_pos_next  = group_pos + 2'd1;
        pad_count_next  = pad_n;
        bad_seen_next   = bad_n;
      end
    end

    if (src.in_last) begin
      group_bits_next = 24'd0;
      group_pos_next  = 2'd0;
      pad_count_next  = 2'd0;
      bad_seen_next   = 1'b0;
    end
  end

  // mode register and group state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_ENCODE;
      group_bits <= 24'd0;
      group_pos  <= 2'd0;
      pad_count  <= 2'd0;
      bad_seen   <= 1'b0;
    end else if (cfg.valid) begin
      mode       <= cfg.mode;
      group_bits <= 24'd0;
      group_pos  <= 2'd0;
      pad_count  <= 2'd0;
      bad_seen   <= 1'b0;
    end else if (accept) begin
      group_bits <= group_bits_next;
      group_pos  <= group_pos_next;
      pad_count  <= pad_count_next;
      bad_seen   <= bad_seen_next;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/b64c_queue.sv =====
// short job queue between the front and the back
// depends on b64c_pkg
`default_nettype none

module b64c_queue import b64c_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire job_t push_job,
  input  wire logic pop,
  output logic      full,
  output logic      head_valid,
  output job_t      head_job
);

  job_t                entries [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   count;

  assign full       = (count == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_job   = entries[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/b64c_back.sv =====
// back end: expands each job into result transactions, one per cycle unless the result side stalls
// depends on b64c_pkg, the b64c interfaces and base64_codec_top_defines.svh
`default_nettype none
`include "base64_codec_top_defines.svh"

module b64c_back import b64c_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  head_valid,
  input  wire job_t  head_job,
  output logic       pop,
  b64c_out_if.source dst
);

  job_t       cur;
  logic       busy;
  logic [1:0] idx;
  logic       out_valid;
  logic [7:0] out_byte;
  logic       out_last;
  logic       out_err;

  job_t       job;
  logic       can_out;
  logic       step;
  logic       final_res;
  logic [5:0] sext;
  logic [7:0] res_byte;

  assign dst.valid    = out_valid;
  assign dst.out_byte = out_byte;
  assign dst.out_last = out_last;
  assign dst.error    = out_err;

  assign job       = busy ? cur : head_job;
  assign can_out   = !out_valid || dst.ready;
  assign step      = can_out && (busy || head_valid);
  assign final_res = (idx == job.cnt_m1);
  assign pop       = step && !busy;

  // result byte for the current slot
  always_comb begin
    case (idx)
      2'd0:    sext = job.bits[23:18];
      2'd1:    sext = job.bits[17:12];
      2'd2:    sext = job.bits[11:6];
      default: sext = job.bits[5:0];
    endcase
    if (job.enc) begin
      res_byte = (idx <= job.sig_m1) ? enc_char(sext) : PAD_CHAR;
    end else begin
      case (idx)
        2'd0:    res_byte = job.bits[23:16];
        2'd1:    res_byte = job.bits[15:8];
        default: res_byte = job.bits[7:0];
      endcase
    end
  end

  // job sequencing and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      idx       <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      if (step) begin
        out_valid <= 1'b1;
        out_byte  <= res_byte;
        out_last  <= job.last && final_res;
        out_err   <= job.err;
        if (final_res) begin
          busy <= 1'b0;
          idx  <= 2'd0;
        end else begin
          busy <= 1'b1;
          idx  <= idx + 2'd1;
          if (!busy) begin
            cur <= head_job;
          end
        end
      end else if (dst.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `B64C_ASSERT_NEVER(a_idx_in_range, clk, rst, busy && (idx > cur.cnt_m1))
  `B64C_ASSERT_IMP(a_pop_has_job, clk, rst, pop, head_valid)
  `B64C_ASSERT_IMP(a_enc_no_err, clk, rst, step && job.enc, !job.err)
  `B64C_ASSERT_IMP(a_enc_four, clk, rst, step && job.enc, job.cnt_m1 == 2'd3)

endmodule

`default_nettype wire

// ===== hdl/base64_codec_top.sv =====
// base64 codec: one result per cycle unless the result side stalls, which sets
// the pace; a result passes the job queue and output register after the item
// ending its group; encode takes 3 items per 4 results, decode one item per
// cycle while the small job queue, which decouples front and back, has room
// reset is synchronous: mode returns to encode, group state and queue empty
// depends on b64c_pkg, b64c interfaces, b64c_front, b64c_queue, b64c_back
`default_nettype none

module base64_codec_top import b64c_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  b64c_cfg_if.sink   cfg,
  b64c_in_if.sink    src,
  b64c_out_if.source dst
);

  logic q_full;
  logic q_push;
  job_t q_job;
  logic q_pop;
  logic head_valid;
  job_t head_job;

  // classify and gather
  b64c_front u_front (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .src    (src),
    .q_full (q_full),
    .q_push (q_push),
    .q_job  (q_job)
  );

  // job queue
  b64c_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_job   (q_job),
    .pop        (q_pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  // result expansion
  b64c_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (q_pop),
    .dst        (dst)
  );

endmodule

`default_nettype wire

// ===== tb/sv/b64c_stream_checker.sv =====
`timescale 1ns / 1ps
// result checker for base64_codec_top: follows the mode, input and result
// channels, predicts each result and compares it with what the block sends
// depends on b64c_pkg and the b64c channel interfaces
module b64c_stream_checker import b64c_pkg::*; (
  input  logic clk,
  input  logic rst,
  b64c_cfg_if  cfg,
  b64c_in_if   src,
  b64c_out_if  dst,
  output int   fail_count,
  output int   pending
);

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       err;
  } codec_result_t;

  localparam logic [8*64-1:0] ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  // predicted codec state
  logic          mode_q;
  logic [23:0]   grp_bits;
  logic [1:0]    grp_pos;
  logic [1:0]    pad_cnt;
  logic          bad_flag;
  codec_result_t expected_q[$];

  function automatic logic [7:0] sextet_char(input logic [5:0] v);
    return ALPHABET[8*(63 - int'(v)) +: 8];
  endfunction

  // character to sextet, INVALID_CODE outside the alphabet
  function automatic logic [6:0] char_sextet(input logic [7:0] c);
    if (c >= "A" && c <= "Z") return 7'(c - "A");
    if (c >= "a" && c <= "z") return 7'(c - "a" + 8'd26);
    if (c >= "0" && c <= "9") return 7'(c - "0" + 8'd52);
    if (c == "+") return 7'd62;
    if (c == "/") return 7'd63;
    return INVALID_CODE;
  endfunction

  function automatic void add_result(input logic [7:0] data, input logic last,
                                     input logic err);
    codec_result_t r;
    r.data = data;
    r.last = last;
    r.err  = err;
    expected_q.push_back(r);
  endfunction

  function automatic void clear_group();
    grp_bits = '0;
    grp_pos  = '0;
    pad_cnt  = '0;
    bad_flag = 1'b0;
  endfunction

  // three bytes make four characters, a short final group is padded
  function automatic void encode_item(input logic [7:0] b, input logic last);
    int pos;
    pos = grp_pos;
    grp_bits = grp_bits | (24'(b) << (16 - 8 * pos));
    pos++;
    if (pos == 3 || last) begin
      add_result(sextet_char(grp_bits[23:18]), 1'b0, 1'b0);
      add_result(sextet_char(grp_bits[17:12]), 1'b0, 1'b0);
      add_result((pos >= 2) ? sextet_char(grp_bits[11:6]) : PAD_CHAR, 1'b0, 1'b0);
      add_result((pos == 3) ? sextet_char(grp_bits[5:0]) : PAD_CHAR, last, 1'b0);
    end
    if (pos == 3) begin
      grp_bits = '0;
      pos = 0;
    end
    grp_pos = 2'(pos);
    if (last) clear_group();
  endfunction

  // four characters make up to three bytes; bad or misplaced ones are sticky
  function automatic void decode_item(input logic [7:0] c, input logic last);
    int         pos;
    int         cnt;
    int         i;
    logic [6:0] v;
    pos = grp_pos;
    v = char_sextet(c);
    if (c == PAD_CHAR && pos >= 2 && (pos == 3 || pad_cnt == 2'd0)) begin
      if (pad_cnt < 2'd2) pad_cnt = pad_cnt + 2'd1;
      v = '0;
    end else if (v == INVALID_CODE || pad_cnt != 2'd0) begin
      bad_flag = 1'b1;
      v = '0;
    end
    grp_bits = grp_bits | (24'(v[5:0]) << (18 - 6 * pos));
    pos++;
    if (pos == 4) begin
      cnt = 3 - int'(pad_cnt);
      // padding in a group that does not end the message
      if (pad_cnt != 2'd0 && !last) bad_flag = 1'b1;
      for (i = 0; i < cnt; i++)
        add_result(grp_bits[16 - 8 * i +: 8], last && (i == cnt - 1), bad_flag);
      grp_bits = '0;
      pad_cnt  = '0;
      pos = 0;
    end else if (last) begin
      // message ended on a partial group
      add_result(8'd0, 1'b1, 1'b1);
    end
    grp_pos = 2'(pos);
    if (last) clear_group();
  endfunction

  function automatic void check_result(input logic [7:0] data, input logic last,
                                       input logic err);
    codec_result_t want;
    if (expected_q.size() == 0) begin
      fail_count++;
      if (fail_count <= 10)
        $display("%0t: result byte %02h last %0b error %0b arrived with none expected",
                 $realtime, data, last, err);
    end else begin
      want = expected_q.pop_front();
      if (data !== want.data || last !== want.last || err !== want.err) begin
        fail_count++;
        if (fail_count <= 10)
          $display("%0t: expected byte %02h last %0b error %0b, got byte %02h last %0b error %0b",
                   $realtime, want.data, want.last, want.err, data, last, err);
      end
    end
  endfunction

  // sample every transaction at the clock edge
  always @(posedge clk) begin
    if (rst) begin
      mode_q = MODE_ENCODE;
      clear_group();
      expected_q.delete();
      fail_count = 0;
    end else begin
      if (dst.valid && dst.ready) check_result(dst.out_byte, dst.out_last, dst.error);
      if (cfg.valid && cfg.ready) begin
        mode_q = cfg.mode;
        clear_group();
      end
      if (src.valid && src.ready) begin
        if (mode_q == MODE_ENCODE) encode_item(src.in_byte, src.in_last);
        else decode_item(src.in_byte, src.in_last);
      end
    end
    pending = expected_q.size();
  end

endmodule

// ===== tb/sv/tb_base64_codec_top.sv =====
`timescale 1ns / 1ps
// testbench top for base64_codec_top: clock, reset, mode writes, messages and
// result back-pressure; checking is done by b64c_stream_checker
// depends on b64c_pkg, the b64c interfaces, base64_codec_top and the checker
module tb_base64_codec_top;
  import b64c_pkg::*;

  localparam int WATCHDOG_LIMIT   = 4000;
  localparam int SINK_HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES    = 12;
  localparam int RANDOM_ITEMS     = 72;
  localparam int PHASES           = 6;

  logic       clk = 1'b0;
  logic       rst;
  int         fail_count;
  int         pending;
  int         idle_cycles = 0;
  logic       sink_hold_req = 1'b0;
  logic       src_steady = 1'b0;
  logic [7:0] msg_q[$];

  b64c_cfg_if cfg_ch ();
  b64c_in_if  in_ch ();
  b64c_out_if out_ch ();

  base64_codec_top u_dut (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_ch),
    .src (in_ch),
    .dst (out_ch)
  );

  b64c_stream_checker u_chk (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg_ch),
    .src        (in_ch),
    .dst        (out_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles = idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL base64_codec_top");
      $finish;
    end
  end

  // result side: short and long stalls, steady stretches, one long hold-off
  initial begin : result_sink
    int pick;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (sink_hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (SINK_HOLD_CYCLES) @(posedge clk);
        sink_hold_req = 1'b0;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          out_ch.ready <= 1'b1;
          repeat ($urandom_range(1, 8)) @(posedge clk);
        end else if (pick < 85) begin
          out_ch.ready <= 1'b0;
          repeat ($urandom_range(1, 3)) @(posedge clk);
        end else if (pick < 95) begin
          out_ch.ready <= 1'b1;
          repeat ($urandom_range(30, 80)) @(posedge clk);
        end else begin
          out_ch.ready <= 1'b0;
          repeat ($urandom_range(10, 40)) @(posedge clk);
        end
      end
    end
  end

  // one input transaction, after a random gap unless the message runs steady
  task automatic send_item(input logic [7:0] b, input logic last);
    int pick;
    int gap;
    pick = $urandom_range(0, 99);
    if (src_steady || pick < 60) gap = 0;
    else if (pick < 90) gap = $urandom_range(1, 3);
    else if (pick < 97) gap = $urandom_range(4, 10);
    else gap = $urandom_range(20, 60);
    if (gap > 0) begin
      in_ch.valid   <= 1'b0;
      in_ch.in_byte <= 8'($urandom);
      in_ch.in_last <= 1'($urandom);
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.in_byte <= b;
    in_ch.in_last <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // send the gathered message, marking the final item when it is closed
  task automatic send_queue(input logic close);
    int i;
    src_steady = ($urandom_range(0, 9) == 0);
    for (i = 0; i < msg_q.size(); i++)
      send_item(msg_q[i], close && (i == msg_q.size() - 1));
    msg_q.delete();
  endtask

  task automatic load_bytes(input logic [63:0] bytes, input int n);
    int i;
    for (i = n - 1; i >= 0; i--) msg_q.push_back(bytes[8 * i +: 8]);
  endtask

  task automatic load_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) msg_q.push_back(s[i]);
  endtask

  // stop offering items until every expected result has arrived
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(input logic m);
    drain_results();
    cfg_ch.valid <= 1'b1;
    cfg_ch.mode  <= m;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic [7:0] rand_symbol();
    int v;
    v = $urandom_range(0, 63);
    if (v < 26) return 8'("A" + v);
    if (v < 52) return 8'("a" + v - 26);
    if (v < 62) return 8'("0" + v - 52);
    if (v == 62) return "+";
    return "/";
  endfunction

  // mostly short byte messages, a few longer ones
  task automatic build_encode_msg();
    int len;
    int i;
    int pick;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 20) : $urandom_range(1, 9);
    for (i = 0; i < len; i++) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) msg_q.push_back(8'h00);
      else if (pick == 1) msg_q.push_back(8'hFF);
      else msg_q.push_back(8'($urandom));
    end
  endtask

  // well-formed groups with random padding, a quarter of the messages damaged
  task automatic build_decode_msg();
    int groups;
    int pads;
    int i;
    int n;
    groups = $urandom_range(1, 4);
    for (i = 0; i < 4 * groups; i++) msg_q.push_back(rand_symbol());
    pads = $urandom_range(0, 2);
    if (pads >= 1) msg_q[msg_q.size() - 1] = PAD_CHAR;
    if (pads == 2) msg_q[msg_q.size() - 2] = PAD_CHAR;
    if ($urandom_range(0, 99) >= 75) begin
      case ($urandom_range(0, 3))
        0: msg_q[$urandom_range(0, msg_q.size() - 1)] = 8'($urandom);
        1: msg_q[$urandom_range(0, msg_q.size() - 1)] = PAD_CHAR;
        2: begin
          n = $urandom_range(1, 3);
          for (i = 0; i < n && msg_q.size() > 1; i++) void'(msg_q.pop_back());
        end
        default: begin
          n = $urandom_range(1, 3);
          for (i = 0; i < n; i++) msg_q.push_back(rand_symbol());
        end
      endcase
    end
  endtask

  initial begin : stimulus
    logic phase_mode[PHASES];
    int   p;
    int   phase_items;
    rst = 1'b1;
    cfg_ch.valid  <= 1'b0;
    cfg_ch.mode   <= MODE_ENCODE;
    in_ch.valid   <= 1'b0;
    in_ch.in_byte <= 8'd0;
    in_ch.in_last <= 1'b0;
    phase_mode[0] = MODE_ENCODE;
    phase_mode[1] = MODE_DECODE;
    phase_mode[2] = MODE_DECODE;
    phase_mode[3] = MODE_ENCODE;
    phase_mode[4] = MODE_ENCODE;
    phase_mode[5] = MODE_DECODE;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // encode from reset: one- and two-byte remainders, all-plus group, zeros and ones
    load_bytes(64'h00, 1);
    send_queue(1'b1);
    load_bytes(64'hFFFF, 2);
    send_queue(1'b1);
    load_bytes(64'hFBEFBEFF, 4);
    send_queue(1'b1);

    // decode: every character class with one pad, misplaced pad and bad
    // character, padding before the end with nonzero pad bits, partial group
    write_mode(MODE_DECODE);
    load_text("+/AzZ90=");
    send_queue(1'b1);
    load_text("A=*=");
    send_queue(1'b1);
    load_text("QR==AB");
    send_queue(1'b1);

    // random phases across both modes, the same mode written twice in a row
    for (p = 0; p < PHASES; p++) begin
      write_mode(phase_mode[p]);
      if (p == 2) sink_hold_req = 1'b1;
      phase_items = 0;
      while (phase_items < RANDOM_ITEMS / PHASES) begin
        if (phase_mode[p] == MODE_ENCODE) build_encode_msg();
        else build_decode_msg();
        phase_items += msg_q.size();
        send_queue(1'b1);
        if (p == 4 && phase_items >= RANDOM_ITEMS / (2 * PHASES) &&
            phase_items < RANDOM_ITEMS / (2 * PHASES) + 12)
          drain_results();
      end
      // leave a message open in odd phases so the next mode write, if any, cuts it off
      if (p % 2 == 1) begin
        if (phase_mode[p] == MODE_ENCODE) build_encode_msg();
        else build_decode_msg();
        while (msg_q.size() > 2) void'(msg_q.pop_back());
        send_queue(1'b0);
      end
    end

    drain_results();
    if (fail_count == 0 && pending == 0) $display("PASS base64_codec_top");
    else $display("FAIL base64_codec_top");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/b64c_pkg.sv
hdl/b64c_ifs.sv
hdl/b64c_front.sv
hdl/b64c_queue.sv
hdl/b64c_back.sv
hdl/base64_codec_top.sv
tb/sv/b64c_stream_checker.sv
tb/sv/tb_base64_codec_top.sv
